// File: design/ordlst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordlst_pkg: shared types and constants of the stacking-order list
// Word layouts, operation and status codes, and the control structs that run
// between the control block and the row of list cells.
// ----------------------------------------------------------------------------
package ordlst_pkg;

   // List geometry
   localparam int MAX_WINDOWS = 64;
   localparam int IDX_W       = $clog2(MAX_WINDOWS);
   localparam int CNT_W       = $clog2(MAX_WINDOWS + 1);
   localparam int ID_W        = 32;

   // Register file
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic CSR_IDX_WATCHED = 1'b0;
   localparam logic [ID_W-1:0] WATCHED_RESET = 32'd1;

   // Operation codes
   localparam logic [2:0] OP_CREATE    = 3'd0;
   localparam logic [2:0] OP_CIRCULATE = 3'd1;
   localparam logic [2:0] OP_CONFIGURE = 3'd2;
   localparam logic [2:0] OP_REPARENT  = 3'd3;
   localparam logic [2:0] OP_DESTROY   = 3'd4;

   // Status codes
   localparam logic [2:0] ST_DONE        = 3'd0;
   localparam logic [2:0] ST_IN_PLACE    = 3'd1;
   localparam logic [2:0] ST_FOREIGN     = 3'd2;
   localparam logic [2:0] ST_DUPLICATE   = 3'd3;
   localparam logic [2:0] ST_UNKNOWN_WIN = 3'd4;
   localparam logic [2:0] ST_UNKNOWN_SIB = 3'd5;
   localparam logic [2:0] ST_FULL        = 3'd6;

   // Event word
   typedef struct packed {
      logic [2:0]      operation;
      logic [ID_W-1:0] event_parent;
      logic [ID_W-1:0] window_id;
      logic [ID_W-1:0] sibling_id;
      logic            place_on_top;
      logic [ID_W-1:0] new_parent;
   } req_type;

   // Result word
   typedef struct packed {
      logic [2:0] status;
      logic [6:0] entry_total;
      logic [5:0] position;
   } rsp_type;

   // Lookup keys broadcast to every cell
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [ID_W-1:0]  win_id;
      logic [ID_W-1:0]  sib_id;
      logic             sib_is_top;
   } probe_type;

   // Update command broadcast to every cell
   typedef struct packed {
      logic             load;
      logic [IDX_W-1:0] load_idx;
      logic [ID_W-1:0]  load_id;
      logic             take_below;
      logic             take_above;
      logic [IDX_W-1:0] lo;
      logic [IDX_W-1:0] hi;
   } cmd_type;

   // Lookup results gathered from the row
   typedef struct packed {
      logic             win_found;
      logic [IDX_W-1:0] win_idx;
      logic             sib_found;
      logic [IDX_W-1:0] sib_idx;
   } find_type;

endpackage

// File: design/ordlst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordlst_cell: one slot of the stacking-order list
// Holds one window identifier, matches it against the broadcast keys and
// takes a new value from itself, a neighbor or the load bus.
// ----------------------------------------------------------------------------
module ordlst_cell (
   input  logic                             clock,
   input  logic [ordlst_pkg::IDX_W-1:0]     cell_index,
   input  ordlst_pkg::probe_type            probe,
   input  ordlst_pkg::cmd_type              cmd,
   input  logic [ordlst_pkg::ID_W-1:0]      below_entry,
   input  logic [ordlst_pkg::ID_W-1:0]      above_entry,
   output logic [ordlst_pkg::ID_W-1:0]      entry,
   output logic                             win_hit,
   output logic                             sib_hit
);

   logic [ordlst_pkg::ID_W-1:0]  entry_ff;
   logic [ordlst_pkg::ID_W-1:0]  entry_in;
   logic [ordlst_pkg::CNT_W-1:0] index_ext;
   logic                         occupied;
   logic                         is_top;

   // Slot is live when it sits below the fill count
   assign index_ext = ordlst_pkg::CNT_W'(cell_index);
   assign occupied  = index_ext < probe.count;
   assign is_top    = (index_ext + ordlst_pkg::CNT_W'(1)) == probe.count;

   // Match keys; circulate-to-top uses the top slot as sibling, unless that
   // slot holds a zero identifier, which counts as no sibling at all
   assign win_hit = occupied && (entry_ff == probe.win_id);
   assign sib_hit = probe.sib_is_top ? (is_top && (entry_ff != '0))
                                     : (occupied && (entry_ff == probe.sib_id));

   // Pick next value: load, shift up from below, or shift down from above
   always_comb begin
      entry_in = entry_ff;
      if (cmd.load && (cell_index == cmd.load_idx)) begin
         entry_in = cmd.load_id;
      end else if (cmd.take_below && (cell_index > cmd.lo) && (cell_index <= cmd.hi)) begin
         entry_in = below_entry;
      end else if (cmd.take_above && (cell_index >= cmd.lo) && (cell_index < cmd.hi)) begin
         entry_in = above_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// File: design/ordlst_row.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordlst_row: chain of list cells
// Links each cell to its neighbors and gathers the match flags into the
// positions of the window and of its sibling.
// ----------------------------------------------------------------------------
module ordlst_row (
   input  logic                  clock,
   input  ordlst_pkg::probe_type probe,
   input  ordlst_pkg::cmd_type   cmd,
   output ordlst_pkg::find_type  find
);

   logic [ordlst_pkg::ID_W-1:0]        entries [ordlst_pkg::MAX_WINDOWS];
   logic [ordlst_pkg::MAX_WINDOWS-1:0] win_hits;
   logic [ordlst_pkg::MAX_WINDOWS-1:0] sib_hits;

   // Build the row, edges see zero neighbors
   for (genvar k = 0; k < ordlst_pkg::MAX_WINDOWS; k++) begin : g_cell
      logic [ordlst_pkg::ID_W-1:0] below_w;
      logic [ordlst_pkg::ID_W-1:0] above_w;

      if (k == 0) begin : g_bottom
         assign below_w = '0;
      end else begin : g_inner_lo
         assign below_w = entries[k-1];
      end

      if (k == ordlst_pkg::MAX_WINDOWS - 1) begin : g_top
         assign above_w = '0;
      end else begin : g_inner_hi
         assign above_w = entries[k+1];
      end

      ordlst_cell u_cell (
         .clock       (clock),
         .cell_index  (ordlst_pkg::IDX_W'(k)),
         .probe       (probe),
         .cmd         (cmd),
         .below_entry (below_w),
         .above_entry (above_w),
         .entry       (entries[k]),
         .win_hit     (win_hits[k]),
         .sib_hit     (sib_hits[k])
      );
   end

   // Encode hits; identifiers are unique in the list so at most one fires
   always_comb begin
      find = '0;
      for (int k = 0; k < ordlst_pkg::MAX_WINDOWS; k++) begin
         find.win_found = find.win_found | win_hits[k];
         find.sib_found = find.sib_found | sib_hits[k];
         if (win_hits[k]) begin
            find.win_idx = find.win_idx | ordlst_pkg::IDX_W'(k);
         end
         if (sib_hits[k]) begin
            find.sib_idx = find.sib_idx | ordlst_pkg::IDX_W'(k);
         end
      end
   end

endmodule

// File: design/window_stacking_order_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_stacking_order_list: stacking order of one parent's child windows
// Tracks child window identifiers bottom to top in a row of cells and applies
// create, circulate, configure, reparent and destroy events to it.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | word
//  req     | in        | req_valid / req_ready     | req_data (ordlst_pkg::req_type)
//  rsp     | out       | rsp_valid / rsp_ready     | rsp_data (ordlst_pkg::rsp_type)
//  csr     | in        | APB psel/penable, pready  | watched_parent at byte address 0
//
// Each event passes through capture, a lookup cycle in which every cell
// compares its identifier in parallel, and an update cycle in which the cells
// shift by one slot toward the gap. The next word is taken as soon as the
// update is done, even while the result still waits in the output register.
// Reset clears the fill count and the control state; the slots need no reset.
// A stalled result holds the block in its update cycle.
// ----------------------------------------------------------------------------
module window_stacking_order_list (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  ordlst_pkg::req_type                   req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output ordlst_pkg::rsp_type                   rsp_data,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [ordlst_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ordlst_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ordlst_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                  csr_pready
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_FIND,
      S_EXEC
   } state_type;

   state_type                       state_ff, state_in;
   ordlst_pkg::req_type             req_ff;
   ordlst_pkg::find_type            find_ff;
   ordlst_pkg::find_type            find_w;
   logic [ordlst_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [ordlst_pkg::ID_W-1:0]     watched_ff;
   logic                            rsp_valid_ff;
   ordlst_pkg::rsp_type             rsp_data_ff, rsp_in;
   ordlst_pkg::probe_type           probe;
   ordlst_pkg::cmd_type             cmd;

   logic                            csr_write;
   logic                            req_fire;
   logic                            exec_fire;
   logic                            is_foreign, is_add, is_remove, is_move, sib_none;
   logic                            bi_lt_ci, in_place;
   logic [ordlst_pkg::IDX_W-1:0]    ci, bi, dest, pos;
   logic [2:0]                      status;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == ordlst_pkg::CSR_IDX_WATCHED) ? watched_ff : '0;

   // Handshakes
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign exec_fire = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Lookup keys from the captured event
   always_comb begin
      probe            = '0;
      probe.count      = count_ff;
      probe.win_id     = req_ff.window_id;
      probe.sib_id     = req_ff.sibling_id;
      probe.sib_is_top = (req_ff.operation == ordlst_pkg::OP_CIRCULATE) && req_ff.place_on_top;
   end

   ordlst_row u_row (
      .clock (clock),
      .probe (probe),
      .cmd   (cmd),
      .find  (find_w)
   );

   // Decode the event; a circulate to the top with an empty list or a zero
   // top entry has no sibling and goes to the bottom
   assign is_foreign = (req_ff.operation > ordlst_pkg::OP_DESTROY) ||
                       (req_ff.event_parent != watched_ff);
   assign is_add     = (req_ff.operation == ordlst_pkg::OP_CREATE) ||
                       ((req_ff.operation == ordlst_pkg::OP_REPARENT) &&
                        (req_ff.new_parent == watched_ff));
   assign is_remove  = (req_ff.operation == ordlst_pkg::OP_DESTROY) ||
                       ((req_ff.operation == ordlst_pkg::OP_REPARENT) &&
                        (req_ff.new_parent != watched_ff));
   assign is_move    = (req_ff.operation == ordlst_pkg::OP_CIRCULATE) ||
                       (req_ff.operation == ordlst_pkg::OP_CONFIGURE);
   assign sib_none   = ((req_ff.operation == ordlst_pkg::OP_CONFIGURE) &&
                        (req_ff.sibling_id == '0)) ||
                       ((req_ff.operation == ordlst_pkg::OP_CIRCULATE) &&
                        (!req_ff.place_on_top || !find_ff.sib_found));

   // Move geometry: bottom target counts as sitting below slot zero
   assign ci       = find_ff.win_idx;
   assign bi       = find_ff.sib_idx;
   assign bi_lt_ci = sib_none || (bi < ci);
   assign in_place = sib_none ? (ci == '0)
                              : (((ordlst_pkg::CNT_W'(bi) + ordlst_pkg::CNT_W'(1)) ==
                                  ordlst_pkg::CNT_W'(ci)) || (bi == ci));
   assign dest     = sib_none ? '0 : ((bi < ci) ? (bi + ordlst_pkg::IDX_W'(1)) : bi);

   // Status, cell command and new count
   always_comb begin
      status   = ordlst_pkg::ST_FOREIGN;
      pos      = '0;
      count_in = count_ff;
      cmd      = '0;
      if (is_foreign) begin
         status = ordlst_pkg::ST_FOREIGN;
      end else if (is_add) begin
         if (find_ff.win_found) begin
            status = ordlst_pkg::ST_DUPLICATE;
         end else if (count_ff >= ordlst_pkg::CNT_W'(ordlst_pkg::MAX_WINDOWS)) begin
            status = ordlst_pkg::ST_FULL;
         end else begin
            status       = ordlst_pkg::ST_DONE;
            pos          = ordlst_pkg::IDX_W'(count_ff);
            count_in     = count_ff + ordlst_pkg::CNT_W'(1);
            cmd.load     = 1'b1;
            cmd.load_idx = ordlst_pkg::IDX_W'(count_ff);
            cmd.load_id  = req_ff.window_id;
         end
      end else if (is_remove) begin
         if (!find_ff.win_found) begin
            status = ordlst_pkg::ST_UNKNOWN_WIN;
         end else begin
            status         = ordlst_pkg::ST_DONE;
            pos            = ci;
            count_in       = count_ff - ordlst_pkg::CNT_W'(1);
            cmd.take_above = 1'b1;
            cmd.lo         = ci;
            cmd.hi         = ordlst_pkg::IDX_W'(count_ff - ordlst_pkg::CNT_W'(1));
         end
      end else if (is_move) begin
         if (!find_ff.win_found) begin
            status = ordlst_pkg::ST_UNKNOWN_WIN;
         end else if (!sib_none && !find_ff.sib_found) begin
            status = ordlst_pkg::ST_UNKNOWN_SIB;
         end else if (in_place) begin
            status = ordlst_pkg::ST_IN_PLACE;
            pos    = ci;
         end else begin
            status       = ordlst_pkg::ST_DONE;
            pos          = dest;
            cmd.load     = 1'b1;
            cmd.load_idx = dest;
            cmd.load_id  = req_ff.window_id;
            if (bi_lt_ci) begin
               cmd.take_below = 1'b1;
               cmd.lo         = dest;
               cmd.hi         = ci;
            end else begin
               cmd.take_above = 1'b1;
               cmd.lo         = ci;
               cmd.hi         = dest;
            end
         end
      end
      // Drop the command unless the update cycle really fires
      if (!exec_fire) begin
         cmd      = '0;
         count_in = count_ff;
      end
   end

   always_comb begin
      rsp_in             = '0;
      rsp_in.status      = status;
      rsp_in.entry_total = 7'(count_in);
      rsp_in.position    = 6'(pos);
   end

   // Advance the sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (exec_fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, count, register and output word
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_data;
      end
      if (state_ff == S_FIND) begin
         find_ff <= find_w;
      end
      if (exec_fire) begin
         rsp_data_ff <= rsp_in;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         watched_ff   <= ordlst_pkg::WATCHED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_write && (csr_paddr[2] == ordlst_pkg::CSR_IDX_WATCHED)) begin
            watched_ff <= csr_pwdata;
         end
         if (exec_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ordlst_pkg::CNT_W'(ordlst_pkg::MAX_WINDOWS))
      else $error("fill count above capacity");

   a_count_only_in_exec: assert property (@(posedge clock) disable iff (reset)
      !exec_fire |=> $stable(count_ff))
      else $error("fill count moved outside an update cycle");

   a_reject_keeps_count: assert property (@(posedge clock) disable iff (reset)
      exec_fire && (status != ordlst_pkg::ST_DONE) |=> $stable(count_ff))
      else $error("rejected event changed the fill count");
`endif

endmodule
